### rtl/chrast_pkg.sv
// ----------------------------------------------------------------------------
// chrast_pkg
// Shared types and constants for the channel raster converter: register map,
// operation codes and fixed field widths.
// ----------------------------------------------------------------------------
package chrast_pkg;

    // spacing register is always 32 bits wide
    localparam int SPACING_BITS = 32;

    // configuration port: 64-bit data, four registers at 8-byte strides
    localparam int APB_DATA_BITS = 64;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_LSB   = 3;

    typedef enum logic [1:0] {
        REG_FIRST_FREQ = 2'd0,
        REG_SPACING    = 2'd1,
        REG_LOWEST     = 2'd2,
        REG_HIGHEST    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_FREQ_TO_CHAN = 1'b0,
        OP_CHAN_TO_FREQ = 1'b1
    } op_t;

endpackage

### rtl/channel_raster_conversion.sv
// ----------------------------------------------------------------------------
// channel_raster_conversion
// Converts between RF frequency and channel number on one configured raster.
// ----------------------------------------------------------------------------
// usage:
//   request channel: start/busy with operation, rf_frequency, channel_index.
//   a request is taken at any edge where start is high; busy stays low since
//   the pipeline never stalls, so one request per cycle is sustained.
//   result channel: done strobes for one cycle with valid_res, channel_number
//   and center_frequency; results leave in request order.
//   pipeline: input register, FREQ_BITS restoring-division stages one quotient
//   bit each, one stage for rounding and the 32x32 product, one output stage.
//   config: APB-style, registers at byte addresses 0, 8, 16, 24 (64-bit data).
//   the user must write the registers only while no request is in flight;
//   the block itself does not enforce this, and pready is always high.
//   reset: all raster registers clear to zero (raster disabled) and every
//   pipeline valid bit clears, so no stale result appears after reset.
//   the receiver cannot hold results off; every result is taken when shown.
// ----------------------------------------------------------------------------
module channel_raster_conversion #(
    parameter int FREQ_BITS    = 40,
    parameter int CHANNEL_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // request channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  operation,
    input  logic [FREQ_BITS-1:0]                  rf_frequency,
    input  logic [CHANNEL_BITS-1:0]               channel_index,

    // result channel
    output logic                                  done,
    output logic                                  valid_res,
    output logic [CHANNEL_BITS-1:0]               channel_number,
    output logic [FREQ_BITS-1:0]                  center_frequency,

    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [chrast_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [chrast_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [chrast_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                  pready
);

    localparam int SB      = chrast_pkg::SPACING_BITS;
    localparam int NSTG    = FREQ_BITS;
    localparam int PROD_W  = CHANNEL_BITS + SB;
    localparam int FSUM_W  = ((PROD_W > FREQ_BITS) ? PROD_W : FREQ_BITS) + 1;
    localparam int CSUM_W  = FREQ_BITS + 2;
    localparam int LAT     = FREQ_BITS + 3;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [FREQ_BITS-1:0]    first_freq_reg;
    logic [SB-1:0]           spacing_reg;
    logic [CHANNEL_BITS-1:0] lowest_reg;
    logic [CHANNEL_BITS-1:0] highest_reg;
    logic                    cfg_wr;
    chrast_pkg::cfg_reg_t    cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_sel = chrast_pkg::cfg_reg_t'(
        paddr[chrast_pkg::APB_ADDR_BITS-1:chrast_pkg::REG_IDX_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_freq_reg <= '0;
            spacing_reg    <= '0;
            lowest_reg     <= '0;
            highest_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                chrast_pkg::REG_FIRST_FREQ: first_freq_reg <= pwdata[FREQ_BITS-1:0];
                chrast_pkg::REG_SPACING:    spacing_reg    <= pwdata[SB-1:0];
                chrast_pkg::REG_LOWEST:     lowest_reg     <= pwdata[CHANNEL_BITS-1:0];
                chrast_pkg::REG_HIGHEST:    highest_reg    <= pwdata[CHANNEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            chrast_pkg::REG_FIRST_FREQ:
                prdata = chrast_pkg::APB_DATA_BITS'(first_freq_reg);
            chrast_pkg::REG_SPACING:
                prdata = chrast_pkg::APB_DATA_BITS'(spacing_reg);
            chrast_pkg::REG_LOWEST:
                prdata = chrast_pkg::APB_DATA_BITS'(lowest_reg);
            chrast_pkg::REG_HIGHEST:
                prdata = chrast_pkg::APB_DATA_BITS'(highest_reg);
            default:
                prdata = '0;
        endcase
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // pipeline: stage 0 is the input register, stages 1..NSTG divide
    // ------------------------------------------------------------------
    logic                    vld_reg  [NSTG+1];
    logic                    op_reg   [NSTG+1];
    logic                    bad_reg  [NSTG+1];
    logic [FREQ_BITS-1:0]    dq_reg   [NSTG+1];
    logic [SB-1:0]           rem_reg  [NSTG+1];
    logic [CHANNEL_BITS-1:0] chan_reg [NSTG+1];

    logic                    below_first;
    logic [FREQ_BITS-1:0]    offset_next;

    assign below_first = rf_frequency < first_freq_reg;
    assign offset_next = rf_frequency - first_freq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        op_reg[0]   <= operation;
        bad_reg[0]  <= (spacing_reg == '0) | below_first;
        dq_reg[0]   <= offset_next;
        rem_reg[0]  <= '0;
        chan_reg[0] <= channel_index;
    end

    // one restoring-division step per stage, quotient shifts into dq
    for (genvar k = 0; k < NSTG; k++)
    begin : g_div
        logic [SB:0]   trial;
        logic [SB:0]   diff;
        logic          ge;
        logic [SB-1:0] rem_next;

        assign trial    = {rem_reg[k], dq_reg[k][FREQ_BITS-1]};
        assign diff     = trial - {1'b0, spacing_reg};
        assign ge       = trial >= {1'b0, spacing_reg};
        assign rem_next = ge ? diff[SB-1:0] : trial[SB-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            op_reg[k+1]   <= op_reg[k];
            bad_reg[k+1]  <= bad_reg[k];
            dq_reg[k+1]   <= {dq_reg[k][FREQ_BITS-2:0], ge};
            rem_reg[k+1]  <= rem_next;
            chan_reg[k+1] <= chan_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // rounding and reverse-mode product
    // ------------------------------------------------------------------
    logic                    rnd_vld_reg;
    logic                    rnd_op_reg;
    logic                    rnd_bad_reg;
    logic [FREQ_BITS:0]      rnd_nearest_reg;
    logic [PROD_W-1:0]       rnd_prod_reg;

    logic [SB-1:0]           round_thr;
    logic                    round_up;
    logic [CHANNEL_BITS-1:0] chan_off;
    logic                    rev_bad;

    assign round_thr = spacing_reg - (spacing_reg >> 1);
    assign round_up  = rem_reg[NSTG] >= round_thr;
    assign chan_off  = chan_reg[NSTG] - lowest_reg;
    assign rev_bad   = (spacing_reg == '0) | (chan_reg[NSTG] < lowest_reg)
                     | (chan_reg[NSTG] > highest_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rnd_vld_reg <= 1'b0;
        else
            rnd_vld_reg <= vld_reg[NSTG];
    end

    always_ff @(posedge clk)
    begin
        rnd_op_reg      <= op_reg[NSTG];
        rnd_bad_reg     <= (op_reg[NSTG] == chrast_pkg::OP_CHAN_TO_FREQ)
                           ? rev_bad : bad_reg[NSTG];
        rnd_nearest_reg <= {1'b0, dq_reg[NSTG]} + (FREQ_BITS+1)'(round_up);
        rnd_prod_reg    <= PROD_W'(chan_off) * PROD_W'(spacing_reg);
    end

    // ------------------------------------------------------------------
    // range checks and output register
    // ------------------------------------------------------------------
    logic [CSUM_W-1:0] chan_sum;
    logic [FSUM_W-1:0] freq_sum;
    logic              chan_ok;
    logic              freq_ok;
    logic              res_ok;

    logic                    done_reg;
    logic                    valid_res_reg;
    logic [CHANNEL_BITS-1:0] channel_number_reg;
    logic [FREQ_BITS-1:0]    center_frequency_reg;

    assign chan_sum = CSUM_W'(rnd_nearest_reg) + CSUM_W'(lowest_reg);
    assign freq_sum = FSUM_W'(rnd_prod_reg) + FSUM_W'(first_freq_reg);
    // channel must fit CHANNEL_BITS and stay at or below the last channel
    assign chan_ok  = (chan_sum[CSUM_W-1:CHANNEL_BITS] == '0)
                    & (chan_sum[CHANNEL_BITS-1:0] <= highest_reg);
    assign freq_ok  = freq_sum[FSUM_W-1:FREQ_BITS] == '0;
    assign res_ok   = ~rnd_bad_reg &
                      ((rnd_op_reg == chrast_pkg::OP_CHAN_TO_FREQ) ? freq_ok : chan_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= rnd_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        valid_res_reg        <= res_ok;
        channel_number_reg   <= (res_ok && rnd_op_reg == chrast_pkg::OP_FREQ_TO_CHAN)
                                ? chan_sum[CHANNEL_BITS-1:0] : '0;
        center_frequency_reg <= (res_ok && rnd_op_reg == chrast_pkg::OP_CHAN_TO_FREQ)
                                ? freq_sum[FREQ_BITS-1:0] : '0;
    end

    assign done             = done_reg;
    assign valid_res        = valid_res_reg;
    assign channel_number   = channel_number_reg;
    assign center_frequency = center_frequency_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("request did not complete after fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching request");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (channel_number == '0 && center_frequency == '0))
        else $error("invalid result carries nonzero payload");

    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (channel_number == '0 || center_frequency == '0))
        else $error("both result fields set");

    a_center_above_first: assert property (@(posedge clk) disable iff (!rst_n)
        (done && valid_res && center_frequency != '0)
            |-> (center_frequency >= first_freq_reg))
        else $error("center frequency below first center");

endmodule
